/* src/q2e_pkg.sv */
package q2e_pkg;

	localparam int SW = 32;
	localparam int VW = 36;
	localparam int RW = 62;
	localparam int ROOT_W = 31;
	localparam int ATAN_LEN = 24;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} q2e_in_t;

	typedef struct packed {
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
		logic signed [15:0] roll_angle;
		logic               pitch_clamped;
	} q2e_out_t;

	typedef struct packed {
		logic signed [SW-1:0] sin_arg;
		logic signed [VW-1:0] yaw_y;
		logic signed [VW-1:0] yaw_x;
		logic signed [VW-1:0] roll_y;
		logic signed [VW-1:0] roll_x;
		logic                 clamp;
	} q2e_side_t;

	typedef struct packed {
		q2e_side_t       side;
		logic [RW-1:0]   rad;
	} q2e_work_t;

	// atan(2^-i), 2^31 = pi
	function automatic logic [31:0] atan_entry(input int unsigned idx);
		logic [31:0] r;
		case (idx)
			0: r = 32'h20000000;
			1: r = 32'h12E4051E;
			2: r = 32'h09FB385B;
			3: r = 32'h051111D4;
			4: r = 32'h028B0D43;
			5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;
			7: r = 32'h00517C55;
			8: r = 32'h0028BE53;
			9: r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

/* src/quaternion_to_euler.sv */
// CORDIC_STEPS is capped at 24. Throughput: one item per cycle while out_ready
// does not hold the output; the front pipeline and the back pipeline
// (square root, then CORDIC) run at one item per cycle each, and either
// side stalls when the stage after it cannot take the next item.
// Reset: arst_n clears all valid bits and queue pointers asynchronously.
module quaternion_to_euler #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  q2e_pkg::q2e_in_t    in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output q2e_pkg::q2e_out_t   out_data
);

	localparam int NS = (CORDIC_STEPS > q2e_pkg::ATAN_LEN) ? q2e_pkg::ATAN_LEN : CORDIC_STEPS;

	logic                         push, full, pop, empty, back_en;
	q2e_pkg::q2e_work_t           push_data, head;
	logic                         sq_vld;
	q2e_pkg::q2e_side_t           sq_side;
	logic [q2e_pkg::ROOT_W-1:0]   sq_root;
	logic [15:0]                  p_ang, y_ang, r_ang;
	logic                         cv_sn [NS+1];
	logic                         cl_sn [NS+1];
	logic signed [15:0]           p_s;

	// front: products, sums, saturation of the sine argument, radicand
	q2e_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.push, .full, .push_data
	);

	// queue between front and back lets each side stall on its own
	q2e_queue u_queue (
		.clk, .arst_n, .push, .push_data, .full, .pop, .empty, .head
	);

	// the whole back pipeline advances whenever the output slot is free;
	// empty queue slots enter as bubbles
	assign back_en = !out_valid || out_ready;
	assign pop     = back_en && !empty;

	q2e_isqrt u_isqrt (
		.clk, .arst_n, .en(back_en), .in_vld(pop), .in_work(head),
		.out_vld(sq_vld), .out_side(sq_side), .out_root(sq_root)
	);

	q2e_cordic #(.STEPS(NS)) u_pitch (
		.clk, .en(back_en),
		.vec_y(q2e_pkg::VW'(sq_side.sin_arg)),
		.vec_x(q2e_pkg::VW'({1'b0, sq_root})),
		.angle(p_ang)
	);

	q2e_cordic #(.STEPS(NS)) u_yaw (
		.clk, .en(back_en), .vec_y(sq_side.yaw_y), .vec_x(sq_side.yaw_x), .angle(y_ang)
	);

	q2e_cordic #(.STEPS(NS)) u_roll (
		.clk, .en(back_en), .vec_y(sq_side.roll_y), .vec_x(sq_side.roll_x), .angle(r_ang)
	);

	// track valid and the clamp flag alongside the CORDIC stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NS; i++) cv_sn[i] <= 1'b0;
		end else if (back_en) begin
			cv_sn[0] <= sq_vld;
			for (int i = 1; i <= NS; i++) cv_sn[i] <= cv_sn[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (back_en) begin
			cl_sn[0] <= sq_side.clamp;
			for (int i = 1; i <= NS; i++) cl_sn[i] <= cl_sn[i-1];
		end
	end

	// limit pitch to a quarter turn either way
	always_comb begin
		p_s = $signed(p_ang);
		if (p_s > 16'sd16384) p_s = 16'sd16384;
		else if (p_s < -16'sd16384) p_s = -16'sd16384;
	end

	assign out_valid = cv_sn[NS];
	assign out_data  = '{pitch_angle: p_s, yaw_angle: $signed(y_ang),
	                     roll_angle: $signed(r_ang), pitch_clamped: cl_sn[NS]};

endmodule

/* src/q2e_front.sv */
module q2e_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  q2e_pkg::q2e_in_t     in_data,
	output logic                 push,
	input  logic                 full,
	output q2e_pkg::q2e_work_t   push_data
);

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;
	logic signed [31:0] wx_s1, yz_s1, xz_s1, wy_s1, xy_s1, wz_s1, xx_s1, yy_s1, zz_s1;
	q2e_pkg::q2e_side_t side_s2, side_s3;
	q2e_pkg::q2e_side_t side_nxt;
	logic [q2e_pkg::RW-1:0] rad_s3;
	logic signed [32:0] d_sin, d_yy, d_ys, d_ry, d_rs;
	logic signed [33:0] sarg;
	logic signed [63:0] sq;

	assign en_s3 = !v_s3 || !full;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign push = v_s3 && !full;
	assign push_data = '{side: side_s3, rad: rad_s3};

	always_comb begin
		d_sin = 33'(wx_s1) - 33'(yz_s1);
		d_yy  = 33'(xz_s1) + 33'(wy_s1);
		d_ys  = 33'(xx_s1) + 33'(yy_s1);
		d_ry  = 33'(xy_s1) + 33'(wz_s1);
		d_rs  = 33'(yy_s1) + 33'(zz_s1);
		sarg  = {d_sin, 1'b0};
		side_nxt.clamp = 1'b0;
		if (sarg > 34'sd1073741824) begin
			side_nxt.sin_arg = 32'sd1073741824;
			side_nxt.clamp = 1'b1;
		end else if (sarg < -34'sd1073741824) begin
			side_nxt.sin_arg = -32'sd1073741824;
			side_nxt.clamp = 1'b1;
		end else begin
			side_nxt.sin_arg = 32'(sarg);
		end
		side_nxt.yaw_y  = q2e_pkg::VW'($signed({d_yy, 1'b0}));
		side_nxt.yaw_x  = 36'sd1073741824 - q2e_pkg::VW'($signed({d_ys, 1'b0}));
		side_nxt.roll_y = q2e_pkg::VW'($signed({d_ry, 1'b0}));
		side_nxt.roll_x = 36'sd1073741824 - q2e_pkg::VW'($signed({d_rs, 1'b0}));
	end

	assign sq = side_s2.sin_arg * side_s2.sin_arg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			wx_s1 <= 32'(in_data.quat_w * in_data.quat_x);
			yz_s1 <= 32'(in_data.quat_y * in_data.quat_z);
			xz_s1 <= 32'(in_data.quat_x * in_data.quat_z);
			wy_s1 <= 32'(in_data.quat_w * in_data.quat_y);
			xy_s1 <= 32'(in_data.quat_x * in_data.quat_y);
			wz_s1 <= 32'(in_data.quat_w * in_data.quat_z);
			xx_s1 <= 32'(in_data.quat_x * in_data.quat_x);
			yy_s1 <= 32'(in_data.quat_y * in_data.quat_y);
			zz_s1 <= 32'(in_data.quat_z * in_data.quat_z);
		end
		if (en_s2) side_s2 <= side_nxt;
		if (en_s3) begin
			side_s3 <= side_s2;
			rad_s3  <= q2e_pkg::RW'(64'h1000000000000000) - q2e_pkg::RW'(sq);
		end
	end

endmodule

/* src/q2e_queue.sv */
module q2e_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  q2e_pkg::q2e_work_t   push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output q2e_pkg::q2e_work_t   head
);

	q2e_pkg::q2e_work_t mem [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign full  = (cnt_q == 3'd4);
	assign empty = (cnt_q == 3'd0);
	assign head  = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_data;
	end

endmodule

/* src/q2e_isqrt.sv */
module q2e_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  q2e_pkg::q2e_work_t          in_work,
	output logic                        out_vld,
	output q2e_pkg::q2e_side_t          out_side,
	output logic [q2e_pkg::ROOT_W-1:0]  out_root
);

	localparam int NST = q2e_pkg::ROOT_W;

	logic                         vld_sn  [NST];
	logic [32:0]                  rem_sn  [NST];
	logic [NST-1:0]               root_sn [NST];
	logic [q2e_pkg::RW-1:0]       rad_sn  [NST];
	q2e_pkg::q2e_side_t           side_sn [NST];

	logic [32:0]                  rem_nxt  [NST];
	logic [NST-1:0]               root_nxt [NST];

	// one root bit per stage, most significant first
	always_comb begin
		for (int j = 0; j < NST; j++) begin
			logic [32:0]     rp;
			logic [NST-1:0]  qp;
			logic [1:0]      pair;
			logic [34:0]     cur;
			logic [34:0]     trial;
			rp = (j == 0) ? 33'd0 : rem_sn[(j == 0) ? 0 : j-1];
			qp = (j == 0) ? '0 : root_sn[(j == 0) ? 0 : j-1];
			pair = (j == 0) ? in_work.rad[2*(NST-1) +: 2]
			                : rad_sn[(j == 0) ? 0 : j-1][2*(NST-1-j) +: 2];
			cur = {rp, pair};
			trial = 35'({qp, 2'b01});
			if (cur >= trial) begin
				rem_nxt[j]  = 33'(cur - trial);
				root_nxt[j] = {qp[NST-2:0], 1'b1};
			end else begin
				rem_nxt[j]  = 33'(cur);
				root_nxt[j] = {qp[NST-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NST; j++) vld_sn[j] <= 1'b0;
		end else if (en) begin
			vld_sn[0] <= in_vld;
			for (int j = 1; j < NST; j++) vld_sn[j] <= vld_sn[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_sn[0]  <= in_work.rad;
			side_sn[0] <= in_work.side;
			for (int j = 1; j < NST; j++) begin
				rad_sn[j]  <= rad_sn[j-1];
				side_sn[j] <= side_sn[j-1];
			end
			for (int j = 0; j < NST; j++) begin
				rem_sn[j]  <= rem_nxt[j];
				root_sn[j] <= root_nxt[j];
			end
		end
	end

	assign out_vld  = vld_sn[NST-1];
	assign out_side = side_sn[NST-1];
	assign out_root = root_sn[NST-1];

endmodule

/* src/q2e_cordic.sv */
module q2e_cordic #(
	parameter int STEPS = 16
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [q2e_pkg::VW-1:0]     vec_y,
	input  logic signed [q2e_pkg::VW-1:0]     vec_x,
	output logic [15:0]                       angle
);

	localparam int NS = (STEPS > q2e_pkg::ATAN_LEN) ? q2e_pkg::ATAN_LEN : STEPS;

	logic signed [q2e_pkg::VW-1:0] x_sn [NS+1];
	logic signed [q2e_pkg::VW-1:0] y_sn [NS+1];
	logic [31:0]                   z_sn [NS+1];
	logic                          zero_sn [NS+1];
	logic [31:0]                   rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			// fold the left half-plane onto the right
			zero_sn[0] <= (vec_x == '0) && (vec_y == '0);
			if (vec_x < 0) begin
				if (vec_y >= 0) begin
					x_sn[0] <= vec_y;
					y_sn[0] <= -vec_x;
					z_sn[0] <= 32'h40000000;
				end else begin
					x_sn[0] <= -vec_y;
					y_sn[0] <= vec_x;
					z_sn[0] <= 32'hC0000000;
				end
			end else begin
				x_sn[0] <= vec_x;
				y_sn[0] <= vec_y;
				z_sn[0] <= 32'h0;
			end
			for (int i = 0; i < NS; i++) begin
				zero_sn[i+1] <= zero_sn[i];
				if (y_sn[i] >= 0) begin
					x_sn[i+1] <= x_sn[i] + (y_sn[i] >>> i);
					y_sn[i+1] <= y_sn[i] - (x_sn[i] >>> i);
					z_sn[i+1] <= z_sn[i] + q2e_pkg::atan_entry(i);
				end else begin
					x_sn[i+1] <= x_sn[i] - (y_sn[i] >>> i);
					y_sn[i+1] <= y_sn[i] + (x_sn[i] >>> i);
					z_sn[i+1] <= z_sn[i] - q2e_pkg::atan_entry(i);
				end
			end
		end
	end

	assign rnd   = z_sn[NS] + 32'h00008000;
	assign angle = zero_sn[NS] ? 16'h0 : rnd[31:16];

endmodule

/* bench/quaternion_to_euler_tb.sv */
module quaternion_to_euler_tb;

	localparam int CORDIC_STEPS = 16;
	localparam int LATENCY = ((CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS) + 35;
	localparam longint ONE_Q30 = 64'sd1 << 30;

	// atan(2^-i), 2^31 = pi
	localparam logic [31:0] ATAN_STEP [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	q2e_pkg::q2e_in_t   in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	q2e_pkg::q2e_out_t  out_data;

	q2e_pkg::q2e_in_t   pending_quats[$];
	q2e_pkg::q2e_out_t  expected_angles[$];
	int       send_idle_pct = 30;
	int       recv_idle_pct = 58;
	bit       hold_send = 1'b0;
	int       mismatches = 0;

	quaternion_to_euler #(.CORDIC_STEPS(CORDIC_STEPS)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #5 clk = ~clk;

	// Floor integer square root, bit by bit from the top pair down.
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned root = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	// Vectoring CORDIC: atan2(vy, vx) as a 16-bit binary angle.
	function automatic logic [15:0] vector_angle(longint vy, longint vx);
		logic [31:0] acc = '0;
		longint t, dx, dy;
		int n;
		if (vx == 0 && vy == 0)
			return 16'd0;
		// Pre-rotate left half-plane vectors by a quarter turn.
		if (vx < 0) begin
			t = vx;
			if (vy >= 0) begin
				vx = vy;
				vy = -t;
				acc = 32'h40000000;
			end else begin
				vx = -vy;
				vy = t;
				acc = 32'hC0000000;
			end
		end
		n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
		for (int i = 0; i < n; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy >= 0) begin
				vx += dx;
				vy -= dy;
				acc += ATAN_STEP[i];
			end else begin
				vx -= dx;
				vy += dy;
				acc -= ATAN_STEP[i];
			end
		end
		acc = acc + 32'h8000;
		return acc[31:16];
	endfunction

	function automatic q2e_pkg::q2e_out_t euler_of(q2e_pkg::q2e_in_t q);
		q2e_pkg::q2e_out_t r;
		longint w, x, y, z, s, c;
		int p;
		w = q.quat_w;
		x = q.quat_x;
		y = q.quat_y;
		z = q.quat_z;
		r.pitch_clamped = 1'b0;
		s = 2 * (w * x - y * z);
		// Saturate the asin argument to unit range.
		if (s > ONE_Q30) begin
			s = ONE_Q30;
			r.pitch_clamped = 1'b1;
		end else if (s < -ONE_Q30) begin
			s = -ONE_Q30;
			r.pitch_clamped = 1'b1;
		end
		c = longint'(floor_sqrt(longint'(ONE_Q30 * ONE_Q30 - s * s)));
		p = int'($signed(vector_angle(s, c)));
		if (p > 16384)
			p = 16384;
		if (p < -16384)
			p = -16384;
		r.pitch_angle = p[15:0];
		r.yaw_angle = vector_angle(2 * (x * z + w * y), ONE_Q30 - 2 * (x * x + y * y));
		r.roll_angle = vector_angle(2 * (x * y + w * z), ONE_Q30 - 2 * (y * y + z * z));
		return r;
	endfunction

	// Driver: drop the accepted item, then offer the next one or idle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_angles.push_back(euler_of(pending_quats.pop_front()));
			end
			if (!in_valid || in_ready) begin
				if (pending_quats.size() != 0 && !hold_send &&
				    $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_quats[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		q2e_pkg::q2e_out_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_angles.size() == 0) begin
					$error("unexpected result item %p", out_data);
					mismatches++;
				end else begin
					e = expected_angles.pop_front();
					if (out_data.pitch_angle !== e.pitch_angle) begin
						$error("pitch_angle: expected %0d, got %0d",
						       e.pitch_angle, out_data.pitch_angle);
						mismatches++;
					end
					if (out_data.yaw_angle !== e.yaw_angle) begin
						$error("yaw_angle: expected %0d, got %0d",
						       e.yaw_angle, out_data.yaw_angle);
						mismatches++;
					end
					if (out_data.roll_angle !== e.roll_angle) begin
						$error("roll_angle: expected %0d, got %0d",
						       e.roll_angle, out_data.roll_angle);
						mismatches++;
					end
					if (out_data.pitch_clamped !== e.pitch_clamped) begin
						$error("pitch_clamped: expected %0b, got %0b",
						       e.pitch_clamped, out_data.pitch_clamped);
						mismatches++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic q2e_pkg::q2e_in_t quat_of(int w, int x, int y, int z);
		q2e_pkg::q2e_in_t q;
		q.quat_w = w[15:0];
		q.quat_x = x[15:0];
		q.quat_y = y[15:0];
		q.quat_z = z[15:0];
		return q;
	endfunction

	// Mostly near-unit quaternions, with raw bit patterns and extremes mixed in.
	task automatic queue_random(int count);
		real a[4], mag;
		int v[4];
		int k;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(9);
			if (k < 6) begin
				mag = 0.0;
				for (int i = 0; i < 4; i++) begin
					a[i] = real'($signed($urandom_range(65535) - 32768));
					mag += a[i] * a[i];
				end
				mag = $sqrt(mag) + 1.0;
				for (int i = 0; i < 4; i++)
					v[i] = $rtoi(a[i] / mag * 32767.0);
				pending_quats.push_back(quat_of(v[0], v[1], v[2], v[3]));
			end else if (k < 9) begin
				pending_quats.push_back(q2e_pkg::q2e_in_t'({$urandom, $urandom}));
			end else begin
				for (int i = 0; i < 4; i++)
					v[i] = ($urandom_range(2) == 0) ? -32768 :
					       ($urandom_range(1) == 0) ? 32767 : 0;
				pending_quats.push_back(quat_of(v[0], v[1], v[2], v[3]));
			end
		end
	endtask

	task automatic drain_inputs();
		while (pending_quats.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	initial begin
		// identity, zero and extremes
		pending_quats.push_back(quat_of(32767, 0, 0, 0));
		pending_quats.push_back(quat_of(0, 0, 0, 0));
		pending_quats.push_back(quat_of(-32768, -32768, -32768, -32768));
		pending_quats.push_back(quat_of(32767, 32767, 32767, 32767));
		pending_quats.push_back(quat_of(-32768, 0, 0, 0));
		// asin argument saturated high and low
		pending_quats.push_back(quat_of(32767, 32767, 0, 0));
		pending_quats.push_back(quat_of(32767, -32768, 0, 0));
		pending_quats.push_back(quat_of(0, 0, 32767, 32767));
		// near gimbal lock, pitch close to +-pi/2
		pending_quats.push_back(quat_of(23170, 23170, 0, 0));
		pending_quats.push_back(quat_of(23170, -23170, 0, 0));
		// half turns: left half-plane vectors and the wrap at pi
		pending_quats.push_back(quat_of(0, 32767, 0, 0));
		pending_quats.push_back(quat_of(0, 0, 32767, 0));
		pending_quats.push_back(quat_of(0, 0, 0, 32767));
		pending_quats.push_back(quat_of(0, 0, 0, -32768));
		pending_quats.push_back(quat_of(-23170, 0, 23170, 0));
		pending_quats.push_back(quat_of(-23170, 0, 0, 23170));
		pending_quats.push_back(quat_of(16384, 16384, 16384, 16384));
		pending_quats.push_back(quat_of(16384, -16384, 16384, -16384));
		// non-unit input
		pending_quats.push_back(quat_of(1, 0, 0, 0));
		pending_quats.push_back(quat_of(100, -200, 300, -400));
		queue_random(600);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		drain_inputs();
		// hold the sender until the pipe is empty
		hold_send = 1'b1;
		queue_random(600);
		while (expected_angles.size() != 0)
			@(posedge clk);
		hold_send = 1'b0;
		send_idle_pct = 58;
		recv_idle_pct = 30;

		drain_inputs();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(630);

		drain_inputs();
		while (expected_angles.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && expected_angles.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

/* quaternion_to_euler.f */
src/q2e_pkg.sv
src/q2e_front.sv
src/q2e_queue.sv
src/q2e_isqrt.sv
src/q2e_cordic.sv
src/quaternion_to_euler.sv
bench/quaternion_to_euler_tb.sv
